// ===== rtl/ffba_pkg.sv =====
// Package for the first-fit block allocator.
// Holds the word types, the search token, the table write word and the codes.
// Depends on nothing; every other file of the block uses it.
package ffba_pkg;

  localparam int unsigned MAX_BLOCKS_DEF   = 64;
  localparam int unsigned HEADER_BYTES_DEF = 16;

  // Largest heap the break pointer may ever reach, in bytes.
  localparam logic [16:0] HEAP_SPAN = 17'h10000;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_REJECT    = 2'd1;
  localparam logic [1:0] STATUS_EXHAUSTED = 2'd2;
  localparam logic [1:0] STATUS_FULL      = 2'd3;

  typedef struct packed {
    logic        func;
    logic [15:0] req_size;
    logic [15:0] payload_addr;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] result_addr;
    logic        reused;
  } rsp_t;

  // Search token handed from cell to cell, one cell per cycle.
  typedef struct packed {
    logic        active;
    logic        func;
    logic [15:0] key;
    logic        hit;
    logic        hit_last;
    logic [15:0] hit_start;
  } tok_t;

  // Append of a new block at the end of the table.
  typedef struct packed {
    logic        en;
    logic [15:0] start;
    logic [15:0] size;
  } wr_t;

endpackage

// ===== rtl/ffba_cell.sv =====
// One table entry of the first-fit block allocator, with its stage of the search chain.
// Depends on ffba_pkg.
module ffba_cell #(
  parameter int unsigned HeaderBytes = ffba_pkg::HEADER_BYTES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ffba_pkg::tok_t tok_i,
  output ffba_pkg::tok_t tok_o,
  input  ffba_pkg::wr_t  wr_i,
  input  logic           wr_sel_i,
  input  logic           next_valid_i,
  output logic           valid_o
);

  ffba_pkg::tok_t tok_d, tok_q;
  logic           valid_d, valid_q;
  logic           free_d, free_q;
  logic [15:0]    start_d, start_q;
  logic [15:0]    size_d, size_q;
  logic [16:0]    payload_addr;

  assign payload_addr = {1'b0, start_q} + 17'(HeaderBytes);

  always_comb begin
    tok_d   = tok_i;
    valid_d = valid_q;
    free_d  = free_q;
    start_d = start_q;
    size_d  = size_q;
    if (wr_sel_i && wr_i.en) begin
      start_d = wr_i.start;
      size_d  = wr_i.size;
      free_d  = 1'b0;
      valid_d = 1'b1;
    end
    if (tok_i.active && !tok_i.hit && valid_q) begin
      unique case (tok_i.func)
        ffba_pkg::FUNC_ALLOC: begin
          if (free_q && (size_q >= tok_i.key)) begin
            tok_d.hit       = 1'b1;
            tok_d.hit_start = start_q;
            free_d          = 1'b0;
          end
        end
        default: begin
          if (payload_addr == {1'b0, tok_i.key}) begin
            tok_d.hit       = 1'b1;
            tok_d.hit_start = start_q;
            // The last block is popped; any other is only marked free.
            if (!next_valid_i) begin
              tok_d.hit_last = 1'b1;
              valid_d        = 1'b0;
              free_d         = 1'b0;
            end else begin
              free_d = 1'b1;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q   <= '0;
      valid_q <= 1'b0;
      free_q  <= 1'b0;
    end else begin
      tok_q   <= tok_d;
      valid_q <= valid_d;
      free_q  <= free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    size_q  <= size_d;
  end

  assign tok_o   = tok_q;
  assign valid_o = valid_q;

endmodule

// ===== rtl/ffba_chain.sv =====
// Row of allocator cells, one per table entry, linked in address order.
// Depends on ffba_pkg and ffba_cell.
module ffba_chain #(
  parameter int unsigned MaxBlocks   = ffba_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned HeaderBytes = ffba_pkg::HEADER_BYTES_DEF,
  localparam int unsigned IdxW       = $clog2(MaxBlocks)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ffba_pkg::tok_t  tok_i,
  output ffba_pkg::tok_t  tok_o,
  input  ffba_pkg::wr_t   wr_i,
  input  logic [IdxW-1:0] wr_idx_i
);

  ffba_pkg::tok_t tok[MaxBlocks+1];
  logic           valid[MaxBlocks+1];

  assign tok[0]          = tok_i;
  assign valid[MaxBlocks] = 1'b0;

  for (genvar i = 0; i < MaxBlocks; i++) begin : g_cell
    ffba_cell #(
      .HeaderBytes(HeaderBytes)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .tok_i       (tok[i]),
      .tok_o       (tok[i+1]),
      .wr_i        (wr_i),
      .wr_sel_i    (wr_idx_i == IdxW'(i)),
      .next_valid_i(valid[i+1]),
      .valid_o     (valid[i])
    );
  end

  assign tok_o = tok[MaxBlocks];

endmodule

// ===== rtl/first_fit_block_allocator.sv =====
// Top level of the first-fit block allocator with a bump pointer.
// Depends on ffba_pkg and ffba_chain (which instantiates ffba_cell).
//
//   Channel   Ports                          Direction  Handshake
//   request   start, busy, req_i             in         start high while busy low
//   result    done_o, rsp_o                  out        done_o high for one cycle
//   config    cfg_we_i, cfg_wdata_i          in         cfg_we_i high, no wait
//
// A request word with a zero size or a zero address is answered in the
// cycle after it is taken, and busy stays low. Any other request sends a
// search token down the chain of MaxBlocks cells, one cell per cycle. The
// token passes the launch register and the register of each cell, and the
// result is then registered; busy is high until it appears. Reset empties
// the table and the break pointer and loads the heap limit with 65536; no
// clearing pass is needed. The receiver cannot stall, so each result is
// shown for exactly one cycle.
module first_fit_block_allocator #(
  parameter int unsigned MaxBlocks   = ffba_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned HeaderBytes = ffba_pkg::HEADER_BYTES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  ffba_pkg::req_t req_i,
  output logic           done_o,
  output ffba_pkg::rsp_t rsp_o,
  input  logic           cfg_we_i,
  input  logic [16:0]    cfg_wdata_i
);

  localparam int unsigned IdxW = $clog2(MaxBlocks);
  localparam int unsigned CntW = $clog2(MaxBlocks + 1);

  localparam logic StIdle = 1'b0;
  localparam logic StRun  = 1'b1;

  logic           state_d, state_q;
  logic [16:0]    limit_q;
  logic [CntW-1:0] count_d, count_q;
  logic [16:0]    brk_d, brk_q;
  logic           func_d, func_q;
  logic [15:0]    size_d, size_q;
  ffba_pkg::tok_t launch_d, launch_q;
  ffba_pkg::tok_t tok_out;
  ffba_pkg::wr_t  wr;
  logic           done_d, done_q;
  ffba_pkg::rsp_t rsp_d, rsp_q;
  logic           accept;
  logic           reject;
  logic [17:0]    limit_sat;
  logic [17:0]    total;

  assign busy   = (state_q == StRun);
  assign accept = start && !busy;
  assign reject = (req_i.func == ffba_pkg::FUNC_ALLOC) ? (req_i.req_size == 16'd0)
                                                       : (req_i.payload_addr == 16'd0);

  // The limit is saturated to the span of the heap, so every payload
  // offset fits in sixteen bits.
  assign limit_sat = (limit_q > ffba_pkg::HEAP_SPAN) ? {1'b0, ffba_pkg::HEAP_SPAN}
                                                    : {1'b0, limit_q};
  assign total     = {1'b0, brk_q} + 18'(HeaderBytes) + {2'b00, size_q};

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    brk_d    = brk_q;
    func_d   = func_q;
    size_d   = size_q;
    launch_d = '0;
    done_d   = 1'b0;
    rsp_d    = rsp_q;
    wr       = '0;
    wr.start = brk_q[15:0];
    wr.size  = size_q;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (reject) begin
            done_d = 1'b1;
            rsp_d  = '{status: ffba_pkg::STATUS_REJECT, result_addr: 16'd0, reused: 1'b0};
          end else begin
            state_d         = StRun;
            func_d          = req_i.func;
            size_d          = req_i.req_size;
            launch_d.active = 1'b1;
            launch_d.func   = req_i.func;
            launch_d.key    = (req_i.func == ffba_pkg::FUNC_ALLOC) ? req_i.req_size
                                                                   : req_i.payload_addr;
          end
        end
      end
      default: begin
        if (tok_out.active) begin
          state_d = StIdle;
          done_d  = 1'b1;
          rsp_d   = '{status: ffba_pkg::STATUS_OK, result_addr: 16'd0, reused: 1'b0};
          if (func_q == ffba_pkg::FUNC_ALLOC) begin
            if (tok_out.hit) begin
              rsp_d.result_addr = tok_out.hit_start + 16'(HeaderBytes);
              rsp_d.reused      = 1'b1;
            end else if (count_q >= CntW'(MaxBlocks)) begin
              rsp_d.status = ffba_pkg::STATUS_FULL;
            end else if (total > limit_sat) begin
              rsp_d.status = ffba_pkg::STATUS_EXHAUSTED;
            end else begin
              // Append a new block at the break pointer.
              wr.en             = 1'b1;
              count_d           = count_q + CntW'(1);
              brk_d             = total[16:0];
              rsp_d.result_addr = brk_q[15:0] + 16'(HeaderBytes);
            end
          end else begin
            if (tok_out.hit) begin
              if (tok_out.hit_last) begin
                count_d = count_q - CntW'(1);
                brk_d   = {1'b0, tok_out.hit_start};
              end
            end else begin
              rsp_d.status = ffba_pkg::STATUS_REJECT;
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      limit_q  <= ffba_pkg::HEAP_SPAN;
      count_q  <= '0;
      brk_q    <= '0;
      launch_q <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      brk_q    <= brk_d;
      launch_q <= launch_d;
      done_q   <= done_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d;
    size_q <= size_d;
    rsp_q  <= rsp_d;
  end

  ffba_chain #(
    .MaxBlocks  (MaxBlocks),
    .HeaderBytes(HeaderBytes)
  ) u_chain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tok_i   (launch_q),
    .tok_o   (tok_out),
    .wr_i    (wr),
    .wr_idx_i(count_q[IdxW-1:0])
  );

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the first-fit block allocator.
// Depends on ffba_pkg and first_fit_block_allocator; needs nothing else to run.
// A heap ledger class predicts every answer and checks each result word in order.
module testbench;
  import ffba_pkg::*;

  // The run is stopped here if the block stops answering.
  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned Phases     = 8;
  localparam int unsigned PhaseWords = 228;

  // Heap limit and share of allocations (in per cent) for each random phase.
  // The limit runs through both extremes, a saturating value above 64 KiB and
  // a few tight values that sit below the break left by the phase before.
  localparam logic [16:0] PhaseLimit [Phases] = '{
    17'h10000, 17'h1FFFF, 17'd0, 17'd4096, 17'd700, 17'h0FFFF, 17'd20000, 17'h10000
  };
  localparam int unsigned PhaseAllocPct [Phases] = '{80, 60, 50, 70, 55, 85, 65, 75};

  // The heap ledger keeps its own copy of the block table, the break pointer
  // and the heap limit. Each accepted request word is run through it at once,
  // and the answer it predicts waits in a queue for the result word.
  class heap_ledger;
    logic [15:0] blk_start [MAX_BLOCKS_DEF];
    logic [15:0] blk_size  [MAX_BLOCKS_DEF];
    bit          blk_free  [MAX_BLOCKS_DEF];
    int unsigned blk_count;
    int unsigned brk;
    logic [16:0] heap_limit;
    rsp_t        due_answers [$];
    int unsigned mismatches;

    function new();
      foreach (blk_free[i]) begin
        blk_start[i] = '0;
        blk_size[i]  = '0;
        blk_free[i]  = 1'b0;
      end
      blk_count  = 0;
      brk        = 0;
      heap_limit = HEAP_SPAN;
      mismatches = 0;
    endfunction

    function void set_limit(logic [16:0] value);
      heap_limit = value;
    endfunction

    // The break may never pass 64 KiB, whatever the register holds.
    function int unsigned usable_limit();
      return (heap_limit > HEAP_SPAN) ? 32'(HEAP_SPAN) : 32'(heap_limit);
    endfunction

    // Largest payload an append could still take; zero or less means none.
    function int room();
      return int'(usable_limit()) - int'(brk) - int'(HEADER_BYTES_DEF);
    endfunction

    function logic [15:0] block_addr(int unsigned idx);
      return 16'(blk_start[idx] + HEADER_BYTES_DEF);
    endfunction

    function int unsigned pending();
      return due_answers.size();
    endfunction

    function rsp_t predict_alloc(logic [15:0] size);
      rsp_t        ans;
      int unsigned total;
      ans        = '0;
      ans.status = STATUS_OK;
      if (size == '0) begin
        ans.status = STATUS_REJECT;
        return ans;
      end
      // First fit over the blocks already in the table; no splitting.
      for (int unsigned i = 0; i < blk_count; i++) begin
        if (blk_free[i] && blk_size[i] >= size) begin
          blk_free[i]     = 1'b0;
          ans.result_addr = block_addr(i);
          ans.reused      = 1'b1;
          return ans;
        end
      end
      if (blk_count >= MAX_BLOCKS_DEF) begin
        ans.status = STATUS_FULL;
        return ans;
      end
      total = brk + HEADER_BYTES_DEF + size;
      if (total > usable_limit()) begin
        ans.status = STATUS_EXHAUSTED;
        return ans;
      end
      // Append at the break pointer.
      blk_start[blk_count] = brk[15:0];
      blk_size[blk_count]  = size;
      blk_free[blk_count]  = 1'b0;
      blk_count++;
      ans.result_addr = 16'(brk + HEADER_BYTES_DEF);
      brk = total;
      return ans;
    endfunction

    function rsp_t predict_release(logic [15:0] addr);
      rsp_t ans;
      ans        = '0;
      ans.status = STATUS_REJECT;
      if (addr == '0) return ans;
      for (int unsigned i = 0; i < blk_count; i++) begin
        if (blk_start[i] + HEADER_BYTES_DEF == addr) begin
          // The last block is popped and gives its bytes back to the break;
          // any other block is only marked free, even if it already was.
          if (i + 1 == blk_count) begin
            brk         = blk_start[i];
            blk_free[i] = 1'b0;
            blk_count--;
          end else begin
            blk_free[i] = 1'b1;
          end
          ans.status = STATUS_OK;
          return ans;
        end
      end
      return ans;
    endfunction

    function void note_request(req_t word);
      if (word.func == FUNC_ALLOC) due_answers.push_back(predict_alloc(word.req_size));
      else due_answers.push_back(predict_release(word.payload_addr));
    endfunction

    task flag(string what, logic [15:0] got, logic [15:0] want);
      mismatches++;
      $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
    endtask

    task check_result(rsp_t got);
      rsp_t want;
      if (due_answers.size() == 0) begin
        flag("unexpected result word", {14'd0, got.status}, '0);
        return;
      end
      want = due_answers.pop_front();
      if (got.status !== want.status)
        flag("status", {14'd0, got.status}, {14'd0, want.status});
      if (got.result_addr !== want.result_addr)
        flag("result_addr", got.result_addr, want.result_addr);
      if (got.reused !== want.reused)
        flag("reused", {15'd0, got.reused}, {15'd0, want.reused});
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        start       = 1'b0;
  logic        busy;
  req_t        req_i       = '0;
  logic        done_o;
  rsp_t        rsp_o;
  logic        cfg_we_i    = 1'b0;
  logic [16:0] cfg_wdata_i = '0;

  int unsigned cycles = 0;
  heap_ledger  ledger;

  first_fit_block_allocator i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .done_o     (done_o),
    .rsp_o      (rsp_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog: a block that hangs ends the run as a failure.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result words cannot be held off, so each one is checked at the edge that
  // closes the cycle in which done_o is high.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) ledger.check_result(rsp_o);
  end

  // Offers one request word after an idle gap and returns at the edge that
  // takes it. Start is left high, so the caller either offers the next word
  // in the same step or lowers start there; it is never lowered and raised
  // again within one step. The ledger is updated here rather than in a
  // separate monitor, so that the next word is drawn from an up-to-date table.
  task automatic send(input req_t word, input int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= word;
    do @(posedge clk_i); while (busy !== 1'b0);
    ledger.note_request(word);
  endtask

  // Directed words: the value is the size for an allocation and the address
  // for a free; the field that the operation ignores gets random bits.
  task automatic issue(input logic func, input logic [15:0] value);
    req_t word;
    word.func         = func;
    word.req_size     = (func == FUNC_ALLOC) ? value : 16'($urandom);
    word.payload_addr = (func == FUNC_FREE) ? value : 16'($urandom);
    send(word, ($urandom_range(2) == 0) ? 0 : $urandom_range(11));
  endtask

  // The limit is only changed with the block idle and every answer in.
  task automatic write_heap_limit(input logic [16:0] value);
    start <= 1'b0;
    while (ledger.pending() != 0 || busy !== 1'b0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    ledger.set_limit(value);
  endtask

  // Random words are mostly well formed: allocations of small and medium
  // sizes, sizes at or just past the remaining room, and frees of blocks that
  // are really in the table. The rest is zero fields, near-miss addresses and
  // fully random values.
  function automatic req_t draw_request(int unsigned alloc_pct);
    req_t        word;
    int unsigned pick;
    int          headroom;
    word.func         = ($urandom_range(99) < alloc_pct) ? FUNC_ALLOC : FUNC_FREE;
    word.req_size     = 16'($urandom);
    word.payload_addr = 16'($urandom);
    pick              = $urandom_range(99);
    if (word.func == FUNC_ALLOC) begin
      headroom = ledger.room();
      if (pick < 3) word.req_size = '0;
      else if (pick < 60) word.req_size = 16'($urandom_range(64, 1));
      else if (pick < 85) word.req_size = 16'($urandom_range(2048, 1));
      else if (pick >= 95 && headroom >= 1) word.req_size = 16'(headroom + $urandom_range(1));
    end else begin
      if (pick < 3) begin
        word.payload_addr = '0;
      end else if (pick < 85 && ledger.blk_count > 0) begin
        word.payload_addr = ledger.block_addr($urandom_range(ledger.blk_count - 1));
      end else if (pick < 90 && ledger.blk_count > 0) begin
        word.payload_addr = ledger.block_addr($urandom_range(ledger.blk_count - 1)) + 16'd1;
      end
    end
    return word;
  endfunction

  initial begin
    logic [15:0] popped_addr;
    int unsigned gap;
    bit          steady;
    ledger = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, starting from the reset limit of 64 KiB.
    issue(FUNC_ALLOC, 16'd0);           // zero size is rejected
    issue(FUNC_FREE, 16'd0);            // zero address is rejected
    issue(FUNC_FREE, 16'hFFFF);         // address of no block
    issue(FUNC_ALLOC, 16'd1);
    issue(FUNC_ALLOC, 16'hFFFF);        // largest size no longer fits
    issue(FUNC_ALLOC, 16'd100);
    issue(FUNC_ALLOC, 16'd8);
    issue(FUNC_FREE, ledger.block_addr(1));   // middle block is marked free
    issue(FUNC_FREE, ledger.block_addr(1));   // and freed a second time
    issue(FUNC_ALLOC, 16'd200);         // too big for the hole, so appended
    issue(FUNC_ALLOC, 16'd50);          // fits the hole and reuses it
    popped_addr = ledger.block_addr(ledger.blk_count - 1);
    issue(FUNC_FREE, popped_addr);      // last block is popped
    issue(FUNC_FREE, popped_addr);      // and is now unknown
    issue(FUNC_ALLOC, 16'(ledger.room() + 1));  // one byte past the limit
    issue(FUNC_ALLOC, 16'(ledger.room()));      // fills the heap exactly
    issue(FUNC_ALLOC, 16'd1);
    issue(FUNC_FREE, ledger.block_addr(0));
    issue(FUNC_ALLOC, 16'd1);
    issue(FUNC_FREE, ledger.block_addr(0));

    // A limit of zero sits below the break: appends fail, reuse still works.
    write_heap_limit(17'd0);
    issue(FUNC_ALLOC, 16'd1);
    issue(FUNC_ALLOC, 16'd1);

    // A limit above 64 KiB behaves as 64 KiB.
    write_heap_limit(17'h1FFFF);
    issue(FUNC_FREE, ledger.block_addr(ledger.blk_count - 1));
    issue(FUNC_ALLOC, 16'(ledger.room()));

    // Random phases. Every third phase runs without gaps, so that words follow
    // one another as fast as busy allows; the others mix random idle gaps
    // between words. The table carries over from phase to phase, so a tight limit
    // usually meets a break that already lies beyond it.
    for (int unsigned p = 0; p < Phases; p++) begin
      write_heap_limit(PhaseLimit[p]);
      steady = (p % 3 == 1);
      for (int unsigned n = 0; n < PhaseWords; n++) begin
        gap = (steady || $urandom_range(4) == 0) ? 0 : $urandom_range(11);
        send(draw_request(PhaseAllocPct[p]), gap);
      end
    end

    // Drain: wait for every answer, then one more search time for strays.
    start <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk_i);
    repeat (MAX_BLOCKS_DEF + 8) @(posedge clk_i);
    if (ledger.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
